// ===== src/hsl2rgb_pkg.sv =====
// shared types and constants for the hsl to rgb converter
`timescale 1ns / 1ps

package hsl2rgb_pkg;

	localparam logic [9:0]  HUE_TURN   = 10'd360;
	localparam logic [9:0]  HUE_TWO    = 10'd720;
	localparam logic [6:0]  PCT_FULL   = 7'd100;
	localparam logic [6:0]  LIGHT_HALF = 7'd50;
	localparam logic [7:0]  LIGHT_TWO  = 8'd200;
	localparam logic [8:0]  HUE_60     = 9'd60;
	localparam logic [8:0]  HUE_120    = 9'd120;
	localparam logic [8:0]  HUE_180    = 9'd180;
	localparam logic [8:0]  HUE_240    = 9'd240;
	localparam logic [5:0]  SLOPE_RUN  = 6'd60;
	// ceil(2^48 / 600000), exact for every dividend below 2^28
	localparam logic [28:0] DIV_RECIP  = 29'd469124962;
	localparam int          DIV_SHIFT  = 48;

	typedef struct packed {
		logic [9:0] hue_deg;
		logic [6:0] sat_pct;
		logic [6:0] light_pct;
	} hsl_t;

	typedef struct packed {
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
	} rgb_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// ===== src/hsl2rgb_chan.sv =====
// one color channel: piecewise-linear shape, scale by 255 and divide by 600000
`timescale 1ns / 1ps

module hsl2rgb_chan (
	input  logic                  clk,
	input  hsl2rgb_pkg::stage_en_t en,
	input  logic [13:0]           lo,
	input  logic [13:0]           hi,
	input  logic [8:0]            hue,
	output logic [7:0]            level
);
	import hsl2rgb_pkg::*;

	logic [13:0] diff;
	logic [5:0]  run;
	logic        on_slope;
	logic        on_top;
	logic [19:0] shape_c;
	logic [19:0] shape_s3;
	logic [27:0] scaled_s4;
	logic [56:0] prod;
	logic [7:0]  level_s5;

	assign diff = hi - lo;

	always_comb begin
		on_slope = 1'b0;
		on_top   = 1'b0;
		run      = '0;
		priority if (hue < HUE_60) begin
			on_slope = 1'b1;
			run      = hue[5:0];
		end else if (hue < HUE_180) begin
			on_top = 1'b1;
		end else if (hue < HUE_240) begin
			on_slope = 1'b1;
			run      = 6'(HUE_240 - hue);
		end else begin
			run = '0;
		end
	end

	always_comb begin
		if (on_top) begin
			shape_c = 20'(hi) * 20'(SLOPE_RUN);
		end else if (on_slope) begin
			shape_c = 20'(lo) * 20'(SLOPE_RUN) + 20'(diff) * 20'(run);
		end else begin
			shape_c = 20'(lo) * 20'(SLOPE_RUN);
		end
	end

	assign prod = 57'(scaled_s4) * 57'(DIV_RECIP);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			shape_s3 <= shape_c;
		end
		if (en.s4) begin
			scaled_s4 <= {shape_s3, 8'b0} - 28'(shape_s3);
		end
		if (en.s5) begin
			level_s5 <= prod[DIV_SHIFT +: 8];
		end
	end

	assign level = level_s5;

endmodule

// ===== src/hsl_to_rgb_color.sv =====
// top level of the hsl to rgb converter
`timescale 1ns / 1ps

// Converts one hue/saturation/lightness color to 8-bit red, green and blue
// in a five-stage pipeline, stages 1 to 5 in order: one transfer in and one
// out per clock while the output is taken. Hue wraps modulo 360, saturation
// and lightness clamp at 100. A stalled output holds stage 5; a full stage
// waits only while the next one is full, and empty stages take new colors,
// so the input is held back only when all five are full and out_ready is low.
module hsl_to_rgb_color (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hsl2rgb_pkg::hsl_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output hsl2rgb_pkg::rgb_t out_data
);
	import hsl2rgb_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	stage_en_t en;

	logic [8:0]  hue_c;
	logic [6:0]  sat_c, lit_c;
	logic [8:0]  hue_s1;
	logic [6:0]  sat_s1, lit_s1;

	logic [13:0] sl_c;
	logic [14:0] hi_dark_c, hi_light_c;
	logic [13:0] hi_c, lo_c;
	logic [8:0]  hr_c, hb_c;
	logic [13:0] hi_s2, lo_s2;
	logic [8:0]  hr_s2, hg_s2, hb_s2;

	assign rdy5 = ~v_s5 | out_ready;
	assign rdy4 = ~v_s4 | rdy5;
	assign rdy3 = ~v_s3 | rdy4;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;
	assign in_ready = rdy1;

	assign en.s3 = rdy3 & v_s2;
	assign en.s4 = rdy4 & v_s3;
	assign en.s5 = rdy5 & v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: hue wrap and percent clamp
	always_comb begin
		if (in_data.hue_deg >= HUE_TWO) begin
			hue_c = 9'(in_data.hue_deg - HUE_TWO);
		end else if (in_data.hue_deg >= HUE_TURN) begin
			hue_c = 9'(in_data.hue_deg - HUE_TURN);
		end else begin
			hue_c = in_data.hue_deg[8:0];
		end
		sat_c = (in_data.sat_pct > PCT_FULL) ? PCT_FULL : in_data.sat_pct;
		lit_c = (in_data.light_pct > PCT_FULL) ? PCT_FULL : in_data.light_pct;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			hue_s1 <= hue_c;
			sat_s1 <= sat_c;
			lit_s1 <= lit_c;
		end
	end

	// stage 2: high and low levels, shifted hues
	assign sl_c       = 14'(sat_s1) * 14'(lit_s1);
	assign hi_dark_c  = 15'(lit_s1) * (15'(PCT_FULL) + 15'(sat_s1));
	assign hi_light_c = 15'(PCT_FULL) * (15'(lit_s1) + 15'(sat_s1)) - 15'(sl_c);
	assign hi_c       = (lit_s1 < LIGHT_HALF) ? hi_dark_c[13:0] : hi_light_c[13:0];
	assign lo_c       = 14'(15'(lit_s1) * 15'(LIGHT_TWO) - 15'(hi_c));
	assign hr_c       = (hue_s1 < HUE_240) ? hue_s1 + HUE_120 : hue_s1 - HUE_240;
	assign hb_c       = (hue_s1 >= HUE_120) ? hue_s1 - HUE_120 : hue_s1 + HUE_240;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			hi_s2 <= hi_c;
			lo_s2 <= lo_c;
			hr_s2 <= hr_c;
			hg_s2 <= hue_s1;
			hb_s2 <= hb_c;
		end
	end

	// stages 3 to 5 per channel
	hsl2rgb_chan u_red (
		.clk   (clk),
		.en    (en),
		.lo    (lo_s2),
		.hi    (hi_s2),
		.hue   (hr_s2),
		.level (out_data.red_level)
	);

	hsl2rgb_chan u_green (
		.clk   (clk),
		.en    (en),
		.lo    (lo_s2),
		.hi    (hi_s2),
		.hue   (hg_s2),
		.level (out_data.green_level)
	);

	hsl2rgb_chan u_blue (
		.clk   (clk),
		.en    (en),
		.lo    (lo_s2),
		.hi    (hi_s2),
		.hue   (hb_s2),
		.level (out_data.blue_level)
	);

	assign out_valid = v_s5;

endmodule
